[design/qtll_pkg.sv]
// ============================================================================
// qtll_pkg: shared definitions for the quadtree leaf block lister
// Field widths, grid defaults, leaf size codes, cursor steps, register indexes and sequencer state codes.
// ============================================================================
package qtll_pkg;

    // Payload widths
    localparam int COORD_W    = 13;
    localparam int SIZE_W     = 7;
    localparam int GRID_REG_W = 8;
    localparam int L2_W       = 4;
    localparam int L3_W       = 16;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;

    // Grid defaults
    localparam int DEF_MAX_GRID_DIM = 128;
    localparam logic [GRID_REG_W-1:0] GRID_RESET = 8'd1;

    // Leaf edge lengths
    localparam logic [SIZE_W-1:0] SIZE_4  = 7'd4;
    localparam logic [SIZE_W-1:0] SIZE_8  = 7'd8;
    localparam logic [SIZE_W-1:0] SIZE_16 = 7'd16;
    localparam logic [SIZE_W-1:0] SIZE_32 = 7'd32;
    localparam logic [SIZE_W-1:0] SIZE_64 = 7'd64;

    // Cursor over a 32x32 quadrant in 4x4 units, Z order
    localparam int CUR_W = 6;
    localparam logic [CUR_W:0] STEP_4  = 7'd1;
    localparam logic [CUR_W:0] STEP_8  = 7'd4;
    localparam logic [CUR_W:0] STEP_16 = 7'd16;
    localparam logic [CUR_W:0] STEP_32 = 7'd64;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } qtll_state_t;

endpackage

[design/quadtree_leaf_block_lister.sv]
// ============================================================================
// quadtree_leaf_block_lister: leaf enumerator for 64x64 tile split quadtrees
// Walks one 32x32 quadrant's split flags and lists its leaves in Z order.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one 32x32 quadrant's split
//   flags per transaction; four transactions in Z order form one 64x64 tile,
//   and tiles advance in raster order over grid_cols x grid_rows.
//   Output channel (out_valid / out_stall) carries one leaf per transaction:
//   top-left y, x, edge size, and last_leaf on the final leaf of the item.
//   Walk: a single cursor adder walks the quadrant one leaf per cycle while
//   the output is not stalled, and the input stays stalled from accept
//   until the item's last leaf is loaded, so a new item waits for the walk.
//   After accept the item is captured; its first leaf is then loaded into the output register.
//   An item that yields no leaf (unsplit root, quadrant 1 to 3) skips the
//   walk and does not stall the input.
//   A stalled output holds its leaf and pauses the walk; the last leaf of an
//   item may wait in the output register while the next item is accepted.
//   Reset clears the quadrant/tile counters, sets both grid registers to 1
//   and drops any leaf in flight. Write grid registers only while idle.
// ============================================================================
module quadtree_leaf_block_lister
#(
    parameter int MAX_GRID_DIM = qtll_pkg::DEF_MAX_GRID_DIM
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [qtll_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qtll_pkg::GRID_REG_W-1:0]   cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              root_split,
    input  logic                              quadrant_split,
    input  logic [qtll_pkg::L2_W-1:0]         level2_splits,
    input  logic [qtll_pkg::L3_W-1:0]         level3_splits,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [qtll_pkg::COORD_W-1:0]      leaf_y,
    output logic [qtll_pkg::COORD_W-1:0]      leaf_x,
    output logic [qtll_pkg::SIZE_W-1:0]       leaf_size,
    output logic                              last_leaf
);
    import qtll_pkg::*;

    localparam int CNT_W = (MAX_GRID_DIM > 1) ? $clog2(MAX_GRID_DIM) : 1;
    localparam int CMP_W = (CNT_W + 1 > GRID_REG_W) ? CNT_W + 1 : GRID_REG_W;

    // Configuration and position state
    logic [GRID_REG_W-1:0] grid_cols_reg;
    logic [GRID_REG_W-1:0] grid_rows_reg;
    logic [1:0]            quadrant_index_reg;
    logic [CNT_W-1:0]      tile_column_reg;
    logic [CNT_W-1:0]      tile_row_reg;

    // Sequencer and captured item
    qtll_state_t           state_reg;
    qtll_state_t           state_next;
    logic [CUR_W-1:0]      cursor_reg;
    logic                  root_reg;
    logic                  quad_reg;
    logic [L2_W-1:0]       l2_reg;
    logic [L3_W-1:0]       l3_reg;
    logic [COORD_W-1:0]    ybase_reg;
    logic [COORD_W-1:0]    xbase_reg;

    // Output register
    logic                  out_valid_reg;
    logic [COORD_W-1:0]    leaf_y_reg;
    logic [COORD_W-1:0]    leaf_x_reg;
    logic [SIZE_W-1:0]     leaf_size_reg;
    logic                  last_leaf_reg;

    logic                  accept;
    logic                  load;
    logic                  no_leaf;
    logic [CNT_W:0]        col_inc;
    logic [CNT_W:0]        row_inc;
    logic                  col_wrap;
    logic                  row_wrap;
    logic [CNT_W+5:0]      ty_full;
    logic [CNT_W+5:0]      tx_full;
    logic [SIZE_W-1:0]     walk_size;
    logic [CUR_W:0]        walk_step;
    logic [CUR_W:0]        cursor_sum;
    logic                  walk_last;
    logic [2:0]            y_off;
    logic [2:0]            x_off;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign load      = (state_reg == ST_WALK) && (!out_valid_reg || !out_stall);
    // unsplit root: only quadrant 0 carries the 64x64 leaf
    assign no_leaf   = !root_split && (quadrant_index_reg != 2'd0);

    assign out_valid = out_valid_reg;
    assign leaf_y    = leaf_y_reg;
    assign leaf_x    = leaf_x_reg;
    assign leaf_size = leaf_size_reg;
    assign last_leaf = last_leaf_reg;

    // Tile counter wrap at the grid register or the grid limit
    assign col_inc  = {1'b0, tile_column_reg} + (CNT_W+1)'(1);
    assign row_inc  = {1'b0, tile_row_reg} + (CNT_W+1)'(1);
    assign col_wrap = (CMP_W'(col_inc) >= CMP_W'(grid_cols_reg))
                   || (col_inc >= (CNT_W+1)'(MAX_GRID_DIM));
    assign row_wrap = (CMP_W'(row_inc) >= CMP_W'(grid_rows_reg))
                   || (row_inc >= (CNT_W+1)'(MAX_GRID_DIM));

    // Tile origin in pixels
    assign ty_full = {tile_row_reg, 6'b0};
    assign tx_full = {tile_column_reg, 6'b0};

    // Leaf at the cursor: size and cursor step from the split flags
    always_comb
    begin
        if (!root_reg)
        begin
            walk_size = SIZE_64;
            walk_step = STEP_32;
        end
        else if (!quad_reg)
        begin
            walk_size = SIZE_32;
            walk_step = STEP_32;
        end
        else if (!l2_reg[cursor_reg[5:4]])
        begin
            walk_size = SIZE_16;
            walk_step = STEP_16;
        end
        else if (!l3_reg[cursor_reg[5:2]])
        begin
            walk_size = SIZE_8;
            walk_step = STEP_8;
        end
        else
        begin
            walk_size = SIZE_4;
            walk_step = STEP_4;
        end
    end

    // Shared cursor adder; carry out marks the end of the quadrant
    assign cursor_sum = {1'b0, cursor_reg} + walk_step;
    assign walk_last  = cursor_sum[CUR_W];
    assign y_off      = {cursor_reg[5], cursor_reg[3], cursor_reg[1]};
    assign x_off      = {cursor_reg[4], cursor_reg[2], cursor_reg[0]};

    // Next sequencer state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !no_leaf)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (load && walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            out_valid_reg      <= 1'b0;
            grid_cols_reg      <= GRID_RESET;
            grid_rows_reg      <= GRID_RESET;
            quadrant_index_reg <= 2'd0;
            tile_column_reg    <= '0;
            tile_row_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // hold the leaf while stalled, drop it once taken
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // grid registers; unknown indexes are ignored
            if (cfg_we && (cfg_index == REG_GRID_COLS))
            begin
                grid_cols_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_GRID_ROWS))
            begin
                grid_rows_reg <= cfg_data;
            end

            // advance quadrant, then column, then row
            if (accept)
            begin
                quadrant_index_reg <= quadrant_index_reg + 2'd1;
                if (quadrant_index_reg == 2'd3)
                begin
                    tile_column_reg <= col_wrap ? '0 : col_inc[CNT_W-1:0];
                    if (col_wrap)
                    begin
                        tile_row_reg <= row_wrap ? '0 : row_inc[CNT_W-1:0];
                    end
                end
            end
        end
    end

    // Capture the item and walk the cursor
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            root_reg   <= root_split;
            quad_reg   <= quadrant_split;
            l2_reg     <= level2_splits;
            l3_reg     <= level3_splits;
            cursor_reg <= '0;
            ybase_reg  <= COORD_W'(ty_full)
                        | (root_split ? COORD_W'({quadrant_index_reg[1], 5'b0}) : '0);
            xbase_reg  <= COORD_W'(tx_full)
                        | (root_split ? COORD_W'({quadrant_index_reg[0], 5'b0}) : '0);
        end
        else if (load)
        begin
            cursor_reg <= cursor_sum[CUR_W-1:0];
        end

        if (load)
        begin
            leaf_y_reg    <= ybase_reg | COORD_W'({y_off, 2'b0});
            leaf_x_reg    <= xbase_reg | COORD_W'({x_off, 2'b0});
            leaf_size_reg <= walk_size;
            last_leaf_reg <= walk_last;
        end
    end

    // Checks
    a_size_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (leaf_size_reg == SIZE_4 || leaf_size_reg == SIZE_8
            || leaf_size_reg == SIZE_16 || leaf_size_reg == SIZE_32
            || leaf_size_reg == SIZE_64))
        else $error("leaf size is not a legal block edge");

    a_tile_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && leaf_size_reg == SIZE_64) |-> last_leaf_reg)
        else $error("64x64 leaf not marked as last leaf");

    a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && out_valid_reg) |-> last_leaf_reg)
        else $error("walk ended without a last leaf");

    a_quad_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (quadrant_index_reg == $past(quadrant_index_reg) + 2'd1))
        else $error("quadrant index did not advance on accept");

    a_leaf_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (leaf_y_reg[1:0] == 2'b00 && leaf_x_reg[1:0] == 2'b00))
        else $error("leaf corner not on a 4-pixel grid");

endmodule
